// ===== rtl/core/sha_pkg.sv =====
`default_nettype none

package sha_pkg;

  localparam int unsigned WordW   = 32;
  localparam int unsigned BlockWords = 16;
  localparam int unsigned Rounds  = 64;
  localparam int unsigned DigestWords = 8;

  localparam int unsigned PosW    = $clog2(BlockWords);
  localparam int unsigned RoundW  = $clog2(Rounds);
  localparam int unsigned DIdxW   = $clog2(DigestWords);

  // Block queue between front and back; depth must be a power of two.
  localparam int unsigned QDepth  = 2;
  localparam int unsigned QPtrW   = (QDepth > 1) ? $clog2(QDepth) : 1;
  localparam int unsigned QCntW   = $clog2(QDepth + 1);

  typedef logic [WordW-1:0] word_t;

  typedef struct packed {
    word_t [BlockWords-1:0] words;  // words[0] arrived first
    logic                   last;
  } block_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  typedef enum logic [3:0] {
    BkIdle  = 4'b0001,
    BkRound = 4'b0010,
    BkAdd   = 4'b0100,
    BkEmit  = 4'b1000
  } bk_state_e;

  localparam word_t InitChain [DigestWords] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam word_t RoundK [Rounds] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  function automatic word_t big_sig0(word_t x);
    return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
  endfunction

  function automatic word_t big_sig1(word_t x);
    return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
  endfunction

  function automatic word_t small_sig0(word_t x);
    return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ (x >> 3);
  endfunction

  function automatic word_t small_sig1(word_t x);
    return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ (x >> 10);
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/sha_if.sv =====
`default_nettype none

interface sha_word_if;
  import sha_pkg::*;
  logic  valid;
  logic  ready;
  word_t message_word;
  logic  ends_message;

  modport source (output valid, output message_word, output ends_message, input ready);
  modport sink   (input valid, input message_word, input ends_message, output ready);
endinterface

interface sha_digest_if;
  import sha_pkg::*;
  logic             valid;
  logic             ready;
  word_t            digest_word;
  logic [DIdxW-1:0] digest_index;
  logic             digest_last;

  modport source (output valid, output digest_word, output digest_index, output digest_last,
                  input ready);
  modport sink   (input valid, input digest_word, input digest_index, input digest_last,
                  output ready);
endinterface

`default_nettype wire

// ===== rtl/core/sha_front.sv =====
`default_nettype none

module sha_front import sha_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  sha_word_if.sink  word_i,
  input  q_status_t q_stat_i,
  output logic      push_o,
  output block_t    block_o
);

  logic [PosW-1:0]        pos_q, pos_d;
  word_t [BlockWords-1:0] buf_q;
  logic                   accept;
  logic                   closing;

  assign closing      = (pos_q == PosW'(BlockWords - 1));
  // Stall only on the closing beat when the queue has no room.
  assign word_i.ready = !(closing && q_stat_i.full);
  assign accept       = word_i.valid && word_i.ready;
  assign push_o       = accept && closing;
  assign pos_d        = accept ? pos_q + PosW'(1) : pos_q;

  always_comb begin
    block_o.words                 = buf_q;
    block_o.words[BlockWords-1]   = word_i.message_word;
    block_o.last                  = word_i.ends_message;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
    end else begin
      pos_q <= pos_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      buf_q[pos_q] <= word_i.message_word;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/sha_queue.sv =====
`default_nettype none

module sha_queue import sha_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_i,
  input  block_t    block_i,
  input  logic      pop_i,
  output block_t    block_o,
  output q_status_t stat_o
);

  block_t           mem_q [QDepth];
  logic [QPtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCntW-1:0] cnt_q, cnt_d;

  assign stat_o.full  = (cnt_q == QCntW'(QDepth));
  assign stat_o.empty = (cnt_q == '0);
  assign block_o      = mem_q[rd_ptr_q];

  always_comb begin
    cnt_d = cnt_q;
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + QCntW'(1);
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - QCntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + QPtrW'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + QPtrW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= block_i;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/sha_back.sv =====
`default_nettype none

module sha_back import sha_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  q_status_t   q_stat_i,
  input  block_t      block_i,
  output logic        pop_o,
  sha_digest_if.source digest_o
);

  bk_state_e               state_q, state_d;
  logic [RoundW-1:0]       rnd_q;
  logic [DIdxW-1:0]        idx_q;
  logic                    last_q;
  word_t [DigestWords-1:0] chain_q;
  word_t [DigestWords-1:0] v_q;
  word_t [BlockWords-1:0]  win_q;
  word_t                   w_t, t1, t2;
  logic                    early;
  logic                    emit_hs;

  // Window holds w[t-16..t-1]; for the first 16 rounds it holds the block itself.
  assign early = (rnd_q < RoundW'(BlockWords));
  assign w_t   = early ? win_q[0]
               : small_sig1(win_q[14]) + win_q[9] + small_sig0(win_q[1]) + win_q[0];

  assign t1 = v_q[7] + big_sig1(v_q[4]) + ((v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]))
            + RoundK[rnd_q] + w_t;
  assign t2 = big_sig0(v_q[0]) + ((v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]));

  assign pop_o   = (state_q == BkIdle) && !q_stat_i.empty;
  assign emit_hs = digest_o.valid && digest_o.ready;

  assign digest_o.valid        = (state_q == BkEmit);
  assign digest_o.digest_word  = chain_q[idx_q];
  assign digest_o.digest_index = idx_q;
  assign digest_o.digest_last  = (idx_q == DIdxW'(DigestWords - 1));

  always_comb begin
    state_d = state_q;
    case (state_q)
      BkIdle:  if (pop_o) state_d = BkRound;
      BkRound: if (rnd_q == RoundW'(Rounds - 1)) state_d = BkAdd;
      BkAdd:   state_d = last_q ? BkEmit : BkIdle;
      BkEmit:  if (emit_hs && digest_o.digest_last) state_d = BkIdle;
      default: state_d = BkIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= BkIdle;
      rnd_q   <= '0;
      idx_q   <= '0;
      last_q  <= 1'b0;
      for (int i = 0; i < DigestWords; i++) begin
        chain_q[i] <= InitChain[i];
      end
    end else begin
      state_q <= state_d;
      case (state_q)
        BkIdle: begin
          rnd_q <= '0;
          idx_q <= '0;
          if (pop_o) begin
            last_q <= block_i.last;
          end
        end
        BkRound: rnd_q <= rnd_q + RoundW'(1);
        BkAdd: begin
          for (int i = 0; i < DigestWords; i++) begin
            chain_q[i] <= chain_q[i] + v_q[i];
          end
        end
        BkEmit: begin
          if (emit_hs) begin
            idx_q <= idx_q + DIdxW'(1);
            if (digest_o.digest_last) begin
              for (int i = 0; i < DigestWords; i++) begin
                chain_q[i] <= InitChain[i];
              end
            end
          end
        end
        default: rnd_q <= '0;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      v_q   <= chain_q;
      win_q <= block_i.words;
    end else if (state_q == BkRound) begin
      v_q[7] <= v_q[6];
      v_q[6] <= v_q[5];
      v_q[5] <= v_q[4];
      v_q[4] <= v_q[3] + t1;
      v_q[3] <= v_q[2];
      v_q[2] <= v_q[1];
      v_q[1] <= v_q[0];
      v_q[0] <= t1 + t2;
      for (int i = 0; i < BlockWords - 1; i++) begin
        win_q[i] <= win_q[i+1];
      end
      win_q[BlockWords-1] <= w_t;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/sha256_block_hash.sv =====
// SHA-256 block hasher. From the beat of a block's 16th word to the first digest beat the
//   block passes through queue write, 64 rounds at one per cycle, chain add and emit.
// The block rate is set by the single round unit in the back end; the word port keeps taking
//   beats while up to two blocks wait.
// Reset (rst_ni, async, low): chain to the standard initial value, position and queue empty.
`default_nettype none

module sha256_block_hash import sha_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  sha_word_if.sink     word_i,
  sha_digest_if.source digest_o
);

  // Front: gather words into a block, push it on the closing beat.
  q_status_t q_stat;
  logic      push;
  logic      pop;
  block_t    push_block;
  block_t    head_block;

  sha_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .word_i   (word_i),
    .q_stat_i (q_stat),
    .push_o   (push),
    .block_o  (push_block)
  );

  // Queue: hold finished blocks so the front waits on the rounds only when the queue is full.
  sha_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .block_i (push_block),
    .pop_i   (pop),
    .block_o (head_block),
    .stat_o  (q_stat)
  );

  // Back: run 64 rounds, add into the chain, emit the digest on a closing block.
  sha_back u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .q_stat_i (q_stat),
    .block_i  (head_block),
    .pop_o    (pop),
    .digest_o (digest_o)
  );

  // Never pop an empty queue.
  assert property (@(posedge clk_i) disable iff (!rst_ni) pop |-> !q_stat.empty)
    else $error("pop from empty block queue");

  // Never push into a full queue.
  assert property (@(posedge clk_i) disable iff (!rst_ni) push |-> !q_stat.full)
    else $error("push into full block queue");

  // Last flag marks exactly the final digest word.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    digest_o.valid |-> (digest_o.digest_last == (digest_o.digest_index == DIdxW'(DigestWords - 1))))
    else $error("digest_last out of step with digest_index");

endmodule

`default_nettype wire

// ===== tb/sha256_block_hash_tb.sv =====
module sha256_block_hash_tb;
  import sha_pkg::*;

  // Run shape.
  localparam int unsigned WordTarget    = 410;   // least number of words to push through
  localparam int unsigned CalmAfter     = 340;   // no idling on either side past this word
  localparam int unsigned SqueezeAt     = 150;   // arm the long receiver hold-off here
  localparam int unsigned SqueezeCycles = 1000;  // length of that hold-off
  localparam int unsigned StuckLimit    = 4000;  // cycles with no beat on either port
  localparam int unsigned DrainCycles   = 150;   // quiet time after the last digest beat
  localparam int unsigned DirRows       = 25;

  // SHA-256 round constants and start value of the chain.
  localparam word_t RoundConst [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  localparam word_t ChainStart [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  // Published digest of the three-byte message "abc"; the first directed block is its
  // padded form, so this value is checked as typed rather than recomputed.
  localparam word_t AbcDigest [8] = '{
    32'hba7816bf, 32'h8f01cfea, 32'h414140de, 32'h5dae2223,
    32'hb00361a3, 32'h96177a9c, 32'hb410ff61, 32'hf20015ad
  };

  typedef struct packed {
    word_t msg_word;
    logic  ends_msg;
    logic  typed_digest;  // take the digest from AbcDigest, not the predictor
  } dir_row_t;

  // Directed words: the padded "abc" block with ends flags sprinkled on words that do not
  // close a block (they must be ignored), then the opening of a second message built from
  // extreme patterns. The random part closes that block.
  localparam dir_row_t DirTable [DirRows] = '{
    '{32'h61626380, 1'b0, 1'b0}, '{32'h00000000, 1'b0, 1'b0},
    '{32'h00000000, 1'b1, 1'b0}, '{32'h00000000, 1'b0, 1'b0},
    '{32'h00000000, 1'b0, 1'b0}, '{32'h00000000, 1'b0, 1'b0},
    '{32'h00000000, 1'b0, 1'b0}, '{32'h00000000, 1'b0, 1'b0},
    '{32'h00000000, 1'b0, 1'b0}, '{32'h00000000, 1'b1, 1'b0},
    '{32'h00000000, 1'b0, 1'b0}, '{32'h00000000, 1'b0, 1'b0},
    '{32'h00000000, 1'b0, 1'b0}, '{32'h00000000, 1'b0, 1'b0},
    '{32'h00000000, 1'b0, 1'b0}, '{32'h00000018, 1'b1, 1'b1},
    '{32'hffffffff, 1'b1, 1'b0}, '{32'h00000000, 1'b1, 1'b0},
    '{32'h80000000, 1'b0, 1'b0}, '{32'h00000001, 1'b1, 1'b0},
    '{32'hffffffff, 1'b0, 1'b0}, '{32'h7fffffff, 1'b1, 1'b0},
    '{32'hfffffffe, 1'b0, 1'b0}, '{32'haaaaaaaa, 1'b1, 1'b0},
    '{32'h55555555, 1'b0, 1'b0}
  };

  typedef struct packed {
    word_t            digest_word;
    logic [DIdxW-1:0] digest_index;
    logic             digest_last;
  } digest_beat_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  sha_word_if   word_bus ();
  sha_digest_if digest_bus ();

  sha256_block_hash u_top (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .word_i   (word_bus),
    .digest_o (digest_bus)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Predictor state: running hash, block words / rolling schedule, word count in block.
  word_t        chain_h [8];
  word_t        sched_w [16];
  logic [3:0]   word_pos;
  digest_beat_t pending_digest [$];

  int unsigned  words_sent;
  int unsigned  beats_seen;
  int unsigned  mismatch_count;
  int unsigned  send_pct;
  bit           calm;
  bit           squeeze_req;
  bit           squeeze_done;
  int unsigned  stuck_cycles;
  digest_beat_t digest_want;

  function automatic word_t rot_right(word_t x, int unsigned r);
    return (x >> r) | (x << (32 - r));
  endfunction

  function automatic word_t rounds_sum_a(word_t x);
    return rot_right(x, 2) ^ rot_right(x, 13) ^ rot_right(x, 22);
  endfunction

  function automatic word_t rounds_sum_e(word_t x);
    return rot_right(x, 6) ^ rot_right(x, 11) ^ rot_right(x, 25);
  endfunction

  function automatic word_t expand_sig0(word_t x);
    return rot_right(x, 7) ^ rot_right(x, 18) ^ (x >> 3);
  endfunction

  function automatic word_t expand_sig1(word_t x);
    return rot_right(x, 17) ^ rot_right(x, 19) ^ (x >> 10);
  endfunction

  // Compress the sixteen words held in sched_w into chain_h, expanding the schedule in place.
  function automatic void compress_into_chain();
    word_t v [8];
    word_t w;
    word_t t1;
    word_t t2;
    v = chain_h;
    for (int t = 0; t < 64; t++) begin
      if (t < 16) begin
        w = sched_w[t];
      end else begin
        w = expand_sig1(sched_w[(t - 2) & 15]) + sched_w[(t - 7) & 15]
          + expand_sig0(sched_w[(t - 15) & 15]) + sched_w[t & 15];
        sched_w[t & 15] = w;
      end
      t1 = v[7] + rounds_sum_e(v[4]) + ((v[4] & v[5]) ^ (~v[4] & v[6])) + RoundConst[t] + w;
      t2 = rounds_sum_a(v[0]) + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
      v[7] = v[6];
      v[6] = v[5];
      v[5] = v[4];
      v[4] = v[3] + t1;
      v[3] = v[2];
      v[2] = v[1];
      v[1] = v[0];
      v[0] = t1 + t2;
    end
    for (int n = 0; n < 8; n++) chain_h[n] = chain_h[n] + v[n];
  endfunction

  // Take one accepted word into the predictor; queue the eight digest beats it causes, if any.
  function automatic void absorb_word(word_t w, logic ends_msg, logic typed_digest);
    digest_beat_t beat;
    sched_w[word_pos] = w;
    if (word_pos != 4'd15) begin
      word_pos = word_pos + 4'd1;
      return;
    end
    word_pos = 4'd0;
    compress_into_chain();
    if (ends_msg) begin
      for (int n = 0; n < 8; n++) begin
        beat.digest_word  = typed_digest ? AbcDigest[n] : chain_h[n];
        beat.digest_index = DIdxW'(n);
        beat.digest_last  = (n == 7);
        pending_digest.push_back(beat);
      end
      chain_h = ChainStart;
    end
  endfunction

  function automatic int unsigned pick_idle_pct();
    case ($urandom_range(0, 2))
      0:       return 0;
      1:       return 15;
      default: return 50;
    endcase
  endfunction

  // Bias the payload toward the corners; the rest is uniform.
  function automatic word_t pick_word();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      2:       return word_t'(1) << $urandom_range(0, 31);
      3:       return ~(word_t'(1) << $urandom_range(0, 31));
      default: return $urandom;
    endcase
  endfunction

  task automatic report_mismatch(input string what, input word_t got, input word_t want);
    $display("digest beat %0d: %s got %h want %h", beats_seen, what, got, want);
    mismatch_count++;
  endtask

  // Offer one word, possibly after a short idle burst; return at the edge that took it.
  task automatic offer_word(input word_t w, input logic ends_msg, input logic typed_digest);
    int unsigned gap;
    if (words_sent % 40 == 0) send_pct = pick_idle_pct();
    if (!calm && $urandom_range(0, 99) < send_pct) begin
      gap = $urandom_range(1, 4);
      word_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    word_bus.valid        <= 1'b1;
    word_bus.message_word <= w;
    word_bus.ends_message <= ends_msg;
    do @(posedge clk_i); while (!word_bus.ready);
    absorb_word(w, ends_msg, typed_digest);
    words_sent++;
    if (words_sent == SqueezeAt) squeeze_req = 1'b1;
    if (words_sent >= CalmAfter) calm = 1'b1;
  endtask

  // Stimulus: reset, directed table, then random messages until the target is met and the
  // last block has been closed with the ends flag.
  initial begin
    word_t w;
    logic  ends_msg;
    chain_h        = ChainStart;
    word_pos       = 4'd0;
    words_sent     = 0;
    mismatch_count = 0;
    calm           = 1'b0;
    squeeze_req    = 1'b0;
    send_pct       = 0;
    word_bus.valid        <= 1'b0;
    word_bus.message_word <= '0;
    word_bus.ends_message <= 1'b0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    for (int r = 0; r < DirRows; r++) begin
      offer_word(DirTable[r].msg_word, DirTable[r].ends_msg, DirTable[r].typed_digest);
    end

    while (words_sent < WordTarget || word_pos != 4'd0) begin
      w = pick_word();
      if (word_pos == 4'd15) begin
        // close about half the blocks as message ends; force it on the final block
        ends_msg = (words_sent + 16 >= WordTarget) ? 1'b1 : 1'($urandom_range(0, 1));
      end else begin
        // noise: the flag is ignored here
        ends_msg = ($urandom_range(0, 3) == 0);
      end
      offer_word(w, ends_msg, 1'b0);
    end
    word_bus.valid <= 1'b0;

    // Wait out the remaining digests, then hold a while to catch any stray beat.
    while (pending_digest.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // Receiver: short random stall bursts, quiet stretches, and one long hold-off once a
  // digest is on its way, so the block backs up and stalls the word port.
  initial begin
    int unsigned hold_left;
    int unsigned stall_pct;
    int unsigned phase_cycles;
    hold_left    = 0;
    stall_pct    = 0;
    phase_cycles = 0;
    squeeze_done = 1'b0;
    digest_bus.ready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (phase_cycles % 256 == 0) stall_pct = pick_idle_pct();
      phase_cycles++;
      if (hold_left != 0) begin
        digest_bus.ready <= 1'b0;
        hold_left--;
      end else if (squeeze_req && !squeeze_done && pending_digest.size() != 0) begin
        squeeze_done = 1'b1;
        hold_left    = SqueezeCycles - 1;
        digest_bus.ready <= 1'b0;
      end else if (!calm && $urandom_range(0, 99) < stall_pct) begin
        hold_left = $urandom_range(0, 3);
        digest_bus.ready <= 1'b0;
      end else begin
        digest_bus.ready <= 1'b1;
      end
    end
  end

  // Check each digest beat against the oldest expectation.
  initial beats_seen = 0;

  always @(posedge clk_i) begin
    if (rst_ni && digest_bus.valid && digest_bus.ready) begin
      if (pending_digest.size() == 0) begin
        report_mismatch("unexpected beat, word", digest_bus.digest_word, '0);
      end else begin
        digest_want = pending_digest.pop_front();
        if (digest_bus.digest_word !== digest_want.digest_word) begin
          report_mismatch("digest_word", digest_bus.digest_word, digest_want.digest_word);
        end
        if (digest_bus.digest_index !== digest_want.digest_index) begin
          report_mismatch("digest_index", word_t'(digest_bus.digest_index),
                          word_t'(digest_want.digest_index));
        end
        if (digest_bus.digest_last !== digest_want.digest_last) begin
          report_mismatch("digest_last", word_t'(digest_bus.digest_last),
                          word_t'(digest_want.digest_last));
        end
      end
      beats_seen++;
    end
  end

  // Watchdog: count cycles with no beat on either port; a hang ends the run.
  initial stuck_cycles = 0;

  always @(posedge clk_i) begin
    if ((word_bus.valid && word_bus.ready) || (digest_bus.valid && digest_bus.ready)) begin
      stuck_cycles = 0;
    end else begin
      stuck_cycles++;
    end
    if (stuck_cycles == StuckLimit) begin
      $display("FAILURE");
      $finish;
    end
  end

endmodule

// ===== sha256_block_hash.f =====
rtl/core/sha_pkg.sv
rtl/core/sha_if.sv
rtl/core/sha_front.sv
rtl/core/sha_queue.sv
rtl/core/sha_back.sv
rtl/core/sha256_block_hash.sv
tb/sha256_block_hash_tb.sv
